>>> hdl/fixed_block_pool_allocator_defines.svh
// ----------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define FBPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Widths, reset values, status and register codes, controller interface types.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int unsigned MaxSlots   = 4096;
  localparam int unsigned AlignBytes = 16;

  localparam int unsigned SlotIdxW = $clog2(MaxSlots);
  localparam int unsigned CountW   = $clog2(MaxSlots + 1);

  localparam int unsigned AddrW    = 32;
  localparam int unsigned SizeW    = 16;
  localparam int unsigned BlockW   = 13;
  localparam int unsigned CapW     = 13;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned TotalW   = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned StrideW = BlockW + 1;
  localparam int unsigned SpanW   = StrideW + CountW;

  localparam int unsigned RstBase      = 0;
  localparam int unsigned RstBlockSize = 768;
  localparam int unsigned RstCapacity  = 256;
  localparam int unsigned RstMinReq    = 256;
  localparam int unsigned RstMaxReq    = 1024;
  localparam int unsigned RstEffCap    = (RstCapacity < MaxSlots) ? RstCapacity : MaxSlots;
  localparam int unsigned RstStride    =
      ((RstBlockSize + AlignBytes - 1) / AlignBytes) * AlignBytes;
  localparam int unsigned RstFreshNext =
      (RstEffCap == 0) ? RstBase : RstBase + (RstEffCap - 1) * RstStride;
  localparam int unsigned RstSpan      = RstEffCap * RstStride;

  typedef enum logic [StatusW-1:0] {
    ST_GRANTED     = 3'd0,
    ST_SIZE_MISS   = 3'd1,
    ST_EMPTY_MISS  = 3'd2,
    ST_FREED       = 3'd3,
    ST_NOT_OWNED   = 3'd4,
    ST_FULL_REJECT = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_ADDRESS = 3'd0,
    REG_BLOCK_SIZE   = 3'd1,
    REG_CAPACITY     = 3'd2,
    REG_MIN_REQUEST  = 3'd3,
    REG_MAX_REQUEST  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic latch_item;
    logic exec;
    logic finish;
    logic cfg_write;
    logic geom_mul;
    logic geom_add;
  } fbpa_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic cfg_geom;
  } fbpa_sts_t;

endpackage

>>> hdl/fbpa_if.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator channels
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface fbpa_req_if;
  import fbpa_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic [SizeW-1:0]   request_size;
  logic [AddrW-1:0]   address;
  modport source (output valid, op, request_size, address, input ready);
  modport sink   (input valid, op, request_size, address, output ready);
endinterface

interface fbpa_rsp_if;
  import fbpa_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [AddrW-1:0]   block_address;
  logic [TotalW-1:0]  hit_total;
  logic [TotalW-1:0]  miss_total;
  modport source (output valid, status, block_address, hit_total, miss_total, input ready);
  modport sink   (input valid, status, block_address, hit_total, miss_total, output ready);
endinterface

interface fbpa_cfg_if;
  import fbpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Fixed-size block pool with a LIFO free list and hit/miss counters.
// ----------------------------------------------------------------------------
// Channels: req_i takes allocate (op 0, request_size) and free (op 1, address)
// transactions; rsp_o returns one transaction per request with status,
// block_address and the running hit and miss totals; cfg_i writes the base
// address, block size, capacity and request size window by register index.
// An accepted request passes the execute state, which registers its result
// and the top-of-stack read, then the finish state, which loads rsp_o.
// A new request is taken only after the previous response has left, so
// requests never overlap; the execute state, the response load and the
// response handoff lie between two requests.
// A base, block size or capacity write rebuilds the pool in a multiply state
// and then an add state, during which no transaction is taken; the other
// register writes take effect at once.
// Reset restores the default geometry (base 0, 768-byte blocks, 256 blocks,
// window 256 to 1024 bytes), an empty free list and zero counters; the stack
// memory itself is not cleared.
// A stalled response holds its value until rsp_o.ready; requests wait meanwhile.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator (
  input logic        clk_i,
  input logic        rst_ni,
  fbpa_req_if.sink   req_i,
  fbpa_rsp_if.source rsp_o,
  fbpa_cfg_if.sink   cfg_i
);
  import fbpa_pkg::*;

  fbpa_cmd_t cmd;
  fbpa_sts_t sts;

  fbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .cfg_valid_i (cfg_i.valid),
    .sts_i       (sts),
    .req_ready_o (req_i.ready),
    .cfg_ready_o (cfg_i.ready),
    .cmd_o       (cmd)
  );

  fbpa_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .req_op_i            (req_i.op),
    .req_size_i          (req_i.request_size),
    .req_addr_i          (req_i.address),
    .cfg_index_i         (cfg_i.index),
    .cfg_data_i          (cfg_i.data),
    .rsp_ready_i         (rsp_o.ready),
    .rsp_valid_o         (rsp_o.valid),
    .rsp_status_o        (rsp_o.status),
    .rsp_block_address_o (rsp_o.block_address),
    .rsp_hit_total_o     (rsp_o.hit_total),
    .rsp_miss_total_o    (rsp_o.miss_total)
  );

endmodule

>>> hdl/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator controller
// Sequences request execution, response load and pool geometry rebuild.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                cfg_valid_i,
  input  fbpa_pkg::fbpa_sts_t sts_i,
  output logic                req_ready_o,
  output logic                cfg_ready_o,
  output fbpa_pkg::fbpa_cmd_t cmd_o
);
  import fbpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FINISH,
    S_GEOM_MUL,
    S_GEOM_ADD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cfg_ready_o = (state_q == S_IDLE);
    req_ready_o = (state_q == S_IDLE) && !sts_i.out_busy && !cfg_valid_i;

    cmd_o            = '0;
    cmd_o.cfg_write  = cfg_ready_o && cfg_valid_i;
    cmd_o.latch_item = req_ready_o && req_valid_i;
    cmd_o.exec       = (state_q == S_EXEC);
    cmd_o.finish     = (state_q == S_FINISH);
    cmd_o.geom_mul   = (state_q == S_GEOM_MUL);
    cmd_o.geom_add   = (state_q == S_GEOM_ADD);

    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.cfg_write && sts_i.cfg_geom) begin
          state_d = S_GEOM_MUL;
        end else if (cmd_o.latch_item) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC:     state_d = S_FINISH;
      S_FINISH:   state_d = S_IDLE;
      S_GEOM_MUL: state_d = S_GEOM_ADD;
      S_GEOM_ADD: state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/fbpa_dpath.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator datapath
// Configuration registers, free list stack memory, pool state and counters.
// ----------------------------------------------------------------------------
module fbpa_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fbpa_pkg::fbpa_cmd_t             cmd_i,
  output fbpa_pkg::fbpa_sts_t             sts_o,
  input  logic                            req_op_i,
  input  logic [fbpa_pkg::SizeW-1:0]      req_size_i,
  input  logic [fbpa_pkg::AddrW-1:0]      req_addr_i,
  input  logic [fbpa_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [fbpa_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            rsp_ready_i,
  output logic                            rsp_valid_o,
  output logic [fbpa_pkg::StatusW-1:0]    rsp_status_o,
  output logic [fbpa_pkg::AddrW-1:0]      rsp_block_address_o,
  output logic [fbpa_pkg::TotalW-1:0]     rsp_hit_total_o,
  output logic [fbpa_pkg::TotalW-1:0]     rsp_miss_total_o
);
  import fbpa_pkg::*;

  logic [AddrW-1:0]   base_q;
  logic [BlockW-1:0]  block_q;
  logic [CapW-1:0]    cap_q;
  logic [SizeW-1:0]   min_q;
  logic [SizeW-1:0]   max_q;

  logic [CountW-1:0]  freed_count_q, freed_count_d;
  logic [CountW-1:0]  fresh_left_q, fresh_left_d;
  logic [AddrW-1:0]   fresh_next_q, fresh_next_d;
  logic [SpanW-1:0]   span_q, span_d;
  logic [SpanW-1:0]   prod_q;
  logic [TotalW-1:0]  hit_q, hit_d;
  logic [TotalW-1:0]  miss_q, miss_d;

  logic               op_q;
  logic [SizeW-1:0]   size_q;
  logic [AddrW-1:0]   addr_q;

  status_e            res_status_q, res_status_d;
  logic [AddrW-1:0]   res_addr_q, res_addr_d;
  logic               pop_q, pop_d;

  logic               out_valid_q;
  status_e            out_status_q;
  logic [AddrW-1:0]   out_addr_q;
  logic [TotalW-1:0]  out_hit_q;
  logic [TotalW-1:0]  out_miss_q;

  logic [AddrW-1:0]   mem [MaxSlots];
  logic [AddrW-1:0]   rdata_q;
  logic               mem_we;
  logic [SlotIdxW-1:0] raddr;

  logic [StrideW-1:0] stride;
  logic [CountW-1:0]  eff_cap;
  logic [CountW-1:0]  cap_m1;
  logic [AddrW-1:0]   offset;
  logic               in_window;
  logic               owned;
  logic               list_full;

  // Stride is block size rounded up to the alignment.
  assign stride  = (StrideW'(block_q) + StrideW'(AlignBytes - 1)) & ~StrideW'(AlignBytes - 1);
  assign eff_cap = (cap_q > CapW'(MaxSlots)) ? CountW'(MaxSlots) : CountW'(cap_q);
  assign cap_m1  = (eff_cap == '0) ? '0 : eff_cap - CountW'(1);

  assign in_window = !((size_q < min_q) || (size_q > max_q));
  assign offset    = addr_q - base_q;
  assign owned     = (addr_q >= base_q) && (offset < AddrW'(span_q));
  assign list_full = (({1'b0, freed_count_q} + {1'b0, fresh_left_q}) >= {1'b0, eff_cap}) ||
                     (freed_count_q >= CountW'(MaxSlots));

  assign raddr = SlotIdxW'(freed_count_q - CountW'(1));

  always_comb begin
    sts_o.out_busy = out_valid_q;
    unique case (cfg_reg_e'(cfg_index_i))
      REG_BASE_ADDRESS, REG_BLOCK_SIZE, REG_CAPACITY: sts_o.cfg_geom = 1'b1;
      default:                                        sts_o.cfg_geom = 1'b0;
    endcase
  end

  always_comb begin
    freed_count_d = freed_count_q;
    fresh_left_d  = fresh_left_q;
    fresh_next_d  = fresh_next_q;
    span_d        = span_q;
    hit_d         = hit_q;
    miss_d        = miss_q;
    res_status_d  = res_status_q;
    res_addr_d    = res_addr_q;
    pop_d         = pop_q;
    mem_we        = 1'b0;

    if (cmd_i.geom_add) begin
      freed_count_d = '0;
      fresh_left_d  = eff_cap;
      fresh_next_d  = base_q + AddrW'(prod_q);
      span_d        = (eff_cap == '0) ? '0 : prod_q + SpanW'(stride);
    end

    if (cmd_i.exec) begin
      res_addr_d = '0;
      pop_d      = 1'b0;
      if (!op_q) begin
        if (!in_window) begin
          res_status_d = ST_SIZE_MISS;
          miss_d       = miss_q + TotalW'(1);
        end else if (freed_count_q != '0) begin
          freed_count_d = freed_count_q - CountW'(1);
          pop_d         = 1'b1;
          res_status_d  = ST_GRANTED;
          hit_d         = hit_q + TotalW'(1);
        end else if (fresh_left_q != '0) begin
          res_addr_d   = fresh_next_q;
          fresh_next_d = fresh_next_q - AddrW'(stride);
          fresh_left_d = fresh_left_q - CountW'(1);
          res_status_d = ST_GRANTED;
          hit_d        = hit_q + TotalW'(1);
        end else begin
          res_status_d = ST_EMPTY_MISS;
          miss_d       = miss_q + TotalW'(1);
        end
      end else begin
        if (!owned) begin
          res_status_d = ST_NOT_OWNED;
        end else if (list_full) begin
          res_status_d = ST_FULL_REJECT;
        end else begin
          mem_we        = 1'b1;
          freed_count_d = freed_count_q + CountW'(1);
          res_status_d  = ST_FREED;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q        <= AddrW'(RstBase);
      block_q       <= BlockW'(RstBlockSize);
      cap_q         <= CapW'(RstCapacity);
      min_q         <= SizeW'(RstMinReq);
      max_q         <= SizeW'(RstMaxReq);
      freed_count_q <= '0;
      fresh_left_q  <= CountW'(RstEffCap);
      fresh_next_q  <= AddrW'(RstFreshNext);
      span_q        <= SpanW'(RstSpan);
      hit_q         <= '0;
      miss_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.cfg_write) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_BASE_ADDRESS: base_q  <= cfg_data_i[AddrW-1:0];
          REG_BLOCK_SIZE:   block_q <= cfg_data_i[BlockW-1:0];
          REG_CAPACITY:     cap_q   <= cfg_data_i[CapW-1:0];
          REG_MIN_REQUEST:  min_q   <= cfg_data_i[SizeW-1:0];
          REG_MAX_REQUEST:  max_q   <= cfg_data_i[SizeW-1:0];
          default: ;
        endcase
      end
      freed_count_q <= freed_count_d;
      fresh_left_q  <= fresh_left_d;
      fresh_next_q  <= fresh_next_d;
      span_q        <= span_d;
      hit_q         <= hit_d;
      miss_q        <= miss_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      op_q   <= req_op_i;
      size_q <= req_size_i;
      addr_q <= req_addr_i;
    end
    if (cmd_i.geom_mul) begin
      prod_q <= SpanW'(cap_m1) * SpanW'(stride);
    end
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    pop_q        <= pop_d;
    if (cmd_i.finish) begin
      out_status_q <= res_status_q;
      out_addr_q   <= pop_q ? rdata_q : res_addr_q;
      out_hit_q    <= hit_q;
      out_miss_q   <= miss_q;
    end
  end

  // Free list stack, registered read of the top entry.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[freed_count_q[SlotIdxW-1:0]] <= addr_q;
    end
    rdata_q <= mem[raddr];
  end

  assign rsp_valid_o         = out_valid_q;
  assign rsp_status_o        = out_status_q;
  assign rsp_block_address_o = out_addr_q;
  assign rsp_hit_total_o     = out_hit_q;
  assign rsp_miss_total_o    = out_miss_q;

endmodule

>>> hdl/fbpa_checker.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [fbpa_pkg::StatusW-1:0] rsp_status_i,
  input logic [fbpa_pkg::AddrW-1:0]   rsp_block_address_i,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_i
);
  import fbpa_pkg::*;

  `FBPA_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "response dropped")
  `FBPA_ASSERT_NOW(a_addr_zero, rsp_valid_i && (rsp_status_i != ST_GRANTED), rsp_block_address_i == '0, "address on non-grant")
  `FBPA_ASSERT_NOW(a_no_req_pending, rsp_valid_i, !req_ready_i, "request taken with response pending")
  `FBPA_ASSERT_NOW(a_cfg_req_excl, req_valid_i && req_ready_i, !(cfg_valid_i && cfg_ready_i), "config and request together")
  `FBPA_ASSERT_NEXT(a_min_latency, req_valid_i && req_ready_i, !rsp_valid_i, "response too early")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_valid_i         (req_i.valid),
  .req_ready_i         (req_i.ready),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_status_i        (rsp_o.status),
  .rsp_block_address_i (rsp_o.block_address),
  .cfg_valid_i         (cfg_i.valid),
  .cfg_ready_i         (cfg_i.ready)
);
